>>> hdl/ipn_endpoint_id_parser_top_defines.svh
// Assertion macros shared by the endpoint ID parser RTL.
`ifndef IPN_ENDPOINT_ID_PARSER_TOP_DEFINES_SVH
`define IPN_ENDPOINT_ID_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IPN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IPN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ipn_eid_pkg.sv
// Types, constants and helper functions for the endpoint ID parser.
package ipn_eid_pkg;

    localparam int MAX_EID_LEN_DEF = 128;
    localparam int MIN_EID_LEN     = 7;

    localparam int CHAR_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int NUM_W     = 32;
    localparam int ACC_W     = 64;
    localparam int OUT_BITS  = STATUS_W + 2 * NUM_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h70;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6e;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_NODE,
        PH_SERVICE
    } phase_t;

    typedef enum logic [1:0] {
        SC_SKIP,
        SC_SIGN,
        SC_DIGITS,
        SC_STOP
    } scan_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_SHORT,
        ST_LONG,
        ST_PREFIX,
        ST_NO_DOT,
        ST_BAD_NODE,
        ST_BAD_SERVICE
    } status_t;

    typedef struct packed {
        logic ovf;
        logic dig;
        logic neg;
    } scan_flags_t;

    function automatic logic [CHAR_W-1:0] prefix_char(input logic [1:0] idx);
        logic [CHAR_W-1:0] ch;
        unique case (idx)
            2'd0: ch = CH_I;
            2'd1: ch = CH_P;
            2'd2: ch = CH_N;
            2'd3: ch = CH_COLON;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] ch);
        return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

endpackage

>>> hdl/ipn_endpoint_id_parser_top.sv
// Endpoint ID parser: checks "ipn:N.S" byte by byte and emits node and service numbers.
`include "ipn_endpoint_id_parser_top_defines.svh"

// Takes one character per cycle on the input stream and gives one result
// transaction per string, after the byte marked by tlast. Throughput is one
// byte per clock: the only loop is the per-byte update of the selected
// 64-bit accumulator (times ten plus digit, with overflow check), computed
// combinationally from the input register. A result is loaded into the
// output register as its last byte leaves the input register and sits
// there until taken; input keeps flowing meanwhile, except that a second
// last byte waits in the input register while the previous result is unclaimed.
// Status codes: 0 ok, 1 shorter than 7 bytes, 2 longer than MAX_EID_LEN,
// 3 bad prefix, 4 no dot, 5 bad node, 6 bad service; numbers are zero
// unless status is ok.
module ipn_endpoint_id_parser_top #(
    parameter int MAX_EID_LEN = ipn_eid_pkg::MAX_EID_LEN_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ipn_eid_pkg::CHAR_W-1:0]        s_axis_tdata,  // [7:0] character
    input  logic                                  s_axis_tlast,  // last
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [2:0] status, [34:3] node_number, [66:35] service_number, rest zero
    output logic [ipn_eid_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import ipn_eid_pkg::*;

    localparam int CNT_W = $clog2(MAX_EID_LEN + 2);
    localparam logic [CNT_W-1:0] CNT_SAT    = CNT_W'(MAX_EID_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_EID_LEN);
    localparam logic [CNT_W-1:0] CNT_MIN    = CNT_W'(MIN_EID_LEN);
    localparam logic [CNT_W-1:0] CNT_PREFIX = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_LASTPF = CNT_W'(3);

    // input register
    logic              s1_valid_reg, s1_valid_next;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_last_reg;
    logic              s1_adv;

    // parse state
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_upd;
    phase_t            phase_reg, phase_next, phase_upd;
    scan_t             scan_reg, scan_next, scan_upd;
    logic              prefix_bad_reg, prefix_bad_next, prefix_bad_upd;
    logic              ended_reg, ended_next, ended_upd;
    logic [ACC_W-1:0]  node_acc_reg, node_acc_next, node_acc_upd;
    logic [ACC_W-1:0]  serv_acc_reg, serv_acc_next, serv_acc_upd;
    scan_flags_t       node_flags_reg, node_flags_next, node_flags_upd;
    scan_flags_t       serv_flags_reg, serv_flags_next, serv_flags_upd;

    // shared scanner
    logic [ACC_W-1:0]  sel_acc, sc_acc;
    scan_flags_t       sel_flags, sc_flags;
    scan_t             sc_stage;
    logic [ACC_W+3:0]  acc_x10;
    logic              sc_taken;

    // result
    status_t           res_status;
    logic [NUM_W-1:0]  res_node, res_serv, node_lo, serv_lo;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [NUM_W-1:0]  out_node_reg, out_serv_reg;
    logic              out_load;

    // ------------------------------------------------------------------
    // handshake
    assign s1_adv        = s1_valid_reg && (!s1_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign s1_valid_next = s_axis_tready ? s_axis_tvalid : s1_valid_reg;
    assign out_load      = s1_adv && s1_last_reg;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // scanner on the accumulator of the current phase
    assign sel_acc   = (phase_reg == PH_SERVICE) ? serv_acc_reg : node_acc_reg;
    assign sel_flags = (phase_reg == PH_SERVICE) ? serv_flags_reg : node_flags_reg;
    assign acc_x10   = {1'b0, sel_acc, 3'b000} + {3'b000, sel_acc, 1'b0}
                     + {{(ACC_W){1'b0}}, s1_char_reg[3:0]};

    always_comb
    begin
        sc_stage = scan_reg;
        sc_flags = sel_flags;
        sc_acc   = sel_acc;
        sc_taken = 1'b0;
        if (scan_reg == SC_SKIP)
        begin
            if (is_space(s1_char_reg))
            begin
                sc_taken = 1'b1;
            end
            else if (s1_char_reg == CH_PLUS)
            begin
                sc_stage = SC_SIGN;
                sc_taken = 1'b1;
            end
            else if (s1_char_reg == CH_MINUS)
            begin
                sc_stage     = SC_SIGN;
                sc_flags.neg = 1'b1;
                sc_taken     = 1'b1;
            end
        end
        if (!sc_taken && (scan_reg != SC_STOP))
        begin
            if (!is_digit(s1_char_reg))
            begin
                sc_stage = SC_STOP;
            end
            else
            begin
                sc_stage     = SC_DIGITS;
                sc_flags.dig = 1'b1;
                if (!sel_flags.ovf)
                begin
                    // anything past bit 63 means the magnitude no longer fits
                    if (|acc_x10[ACC_W+3:ACC_W])
                    begin
                        sc_flags.ovf = 1'b1;
                    end
                    else
                    begin
                        sc_acc = acc_x10[ACC_W-1:0];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // next state
    always_comb
    begin
        cnt_upd        = (cnt_reg < CNT_SAT) ? cnt_reg + 1'b1 : cnt_reg;
        phase_upd      = phase_reg;
        scan_upd       = scan_reg;
        prefix_bad_upd = prefix_bad_reg;
        ended_upd      = ended_reg;
        node_acc_upd   = node_acc_reg;
        serv_acc_upd   = serv_acc_reg;
        node_flags_upd = node_flags_reg;
        serv_flags_upd = serv_flags_reg;

        if (cnt_reg < CNT_PREFIX)
        begin
            if (s1_char_reg != prefix_char(cnt_reg[1:0]))
            begin
                prefix_bad_upd = 1'b1;
            end
            if (cnt_reg == CNT_LASTPF)
            begin
                phase_upd = PH_NODE;
            end
        end
        else if (!ended_reg)
        begin
            if (s1_char_reg == CH_NUL)
            begin
                ended_upd = 1'b1;
            end
            else if (phase_reg == PH_NODE)
            begin
                if (s1_char_reg == CH_DOT)
                begin
                    phase_upd = PH_SERVICE;
                    scan_upd  = SC_SKIP;
                end
                else
                begin
                    scan_upd       = sc_stage;
                    node_acc_upd   = sc_acc;
                    node_flags_upd = sc_flags;
                end
            end
            else if (phase_reg == PH_SERVICE)
            begin
                scan_upd       = sc_stage;
                serv_acc_upd   = sc_acc;
                serv_flags_upd = sc_flags;
            end
        end

        // commit; the last byte of a string returns everything to reset
        cnt_next        = cnt_reg;
        phase_next      = phase_reg;
        scan_next       = scan_reg;
        prefix_bad_next = prefix_bad_reg;
        ended_next      = ended_reg;
        node_acc_next   = node_acc_reg;
        serv_acc_next   = serv_acc_reg;
        node_flags_next = node_flags_reg;
        serv_flags_next = serv_flags_reg;
        if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                cnt_next        = '0;
                phase_next      = PH_PREFIX;
                scan_next       = SC_SKIP;
                prefix_bad_next = 1'b0;
                ended_next      = 1'b0;
                node_acc_next   = '0;
                serv_acc_next   = '0;
                node_flags_next = '0;
                serv_flags_next = '0;
            end
            else
            begin
                cnt_next        = cnt_upd;
                phase_next      = phase_upd;
                scan_next       = scan_upd;
                prefix_bad_next = prefix_bad_upd;
                ended_next      = ended_upd;
                node_acc_next   = node_acc_upd;
                serv_acc_next   = serv_acc_upd;
                node_flags_next = node_flags_upd;
                serv_flags_next = serv_flags_upd;
            end
        end
    end

    // ------------------------------------------------------------------
    // result of a string, from the state after its last byte
    assign node_lo = node_acc_upd[NUM_W-1:0];
    assign serv_lo = serv_acc_upd[NUM_W-1:0];

    always_comb
    begin
        res_node = '0;
        res_serv = '0;
        priority if (cnt_upd < CNT_MIN)
        begin
            res_status = ST_SHORT;
        end
        else if (cnt_upd > CNT_MAX)
        begin
            res_status = ST_LONG;
        end
        else if (prefix_bad_upd)
        begin
            res_status = ST_PREFIX;
        end
        else if (phase_upd != PH_SERVICE)
        begin
            res_status = ST_NO_DOT;
        end
        else if (!node_flags_upd.dig || node_flags_upd.ovf)
        begin
            res_status = ST_BAD_NODE;
        end
        else if (!serv_flags_upd.dig || serv_flags_upd.ovf)
        begin
            res_status = ST_BAD_SERVICE;
        end
        else
        begin
            res_status = ST_OK;
            // negation only needs the low word
            res_node = node_flags_upd.neg ? (NUM_W'(0) - node_lo) : node_lo;
            res_serv = serv_flags_upd.neg ? (NUM_W'(0) - serv_lo) : serv_lo;
        end
    end

    // ------------------------------------------------------------------
    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            phase_reg      <= PH_PREFIX;
            scan_reg       <= SC_SKIP;
            prefix_bad_reg <= 1'b0;
            ended_reg      <= 1'b0;
            node_acc_reg   <= '0;
            serv_acc_reg   <= '0;
            node_flags_reg <= '0;
            serv_flags_reg <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            phase_reg      <= phase_next;
            scan_reg       <= scan_next;
            prefix_bad_reg <= prefix_bad_next;
            ended_reg      <= ended_next;
            node_acc_reg   <= node_acc_next;
            serv_acc_reg   <= serv_acc_next;
            node_flags_reg <= node_flags_next;
            serv_flags_reg <= serv_flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_char_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
        if (out_load)
        begin
            out_status_reg <= res_status;
            out_node_reg   <= res_node;
            out_serv_reg   <= res_serv;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                            out_serv_reg, out_node_reg, out_status_reg};

    // ------------------------------------------------------------------
    // assertions
    `IPN_ASSERT_IMPL(a_num_zero_on_err,
        m_axis_tvalid && (out_status_reg != ST_OK),
        (out_node_reg == '0) && (out_serv_reg == '0),
        "numbers must be zero when status is not ok")
    `IPN_ASSERT_NEXT(a_reset_after_last,
        out_load,
        (cnt_reg == '0) && (phase_reg == PH_PREFIX) && !ended_reg && !prefix_bad_reg,
        "parse state not cleared after last byte")
    `IPN_ASSERT_IMPL(a_cnt_sat,
        1'b1,
        cnt_reg <= CNT_SAT,
        "byte count beyond saturation")
    `IPN_ASSERT_IMPL(a_hold_last,
        s1_valid_reg && s1_last_reg && out_valid_reg && !m_axis_tready,
        !s_axis_tready && !s1_adv,
        "last byte consumed while result still pending")

endmodule

>>> verif/ipn_endpoint_id_parser_top_test.sv
// Self-checking testbench for the endpoint ID parser: directed and random "ipn:N.S" strings.
module ipn_endpoint_id_parser_top_test;

    import ipn_eid_pkg::*;

    localparam int MAX_LEN      = MAX_EID_LEN_DEF;
    localparam int RAND_BYTES   = 100;
    localparam int RAND_STRINGS = 5;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        status_t     status;
        logic [31:0] node;
        logic [31:0] service;
    } eid_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CHAR_W-1:0]      s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    ipn_endpoint_id_parser_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser state mirror
    const logic [CHAR_W-1:0] PREFIX_TEXT [4] = '{CH_I, CH_P, CH_N, CH_COLON};
    int          byte_cnt;
    phase_t      cur_phase;
    scan_t       stage;
    logic        prefix_bad;
    logic        text_ended;
    logic [63:0] node_acc;
    logic [63:0] service_acc;
    scan_flags_t node_fl;
    scan_flags_t service_fl;

    eid_result_t expected_ids [$];
    logic [7:0]  text_buf [$];

    bit  quiet;
    int  error_cnt;
    int  bytes_sent;
    int  strings_sent;
    int  cycle_cnt;
    int  sink_stall;
    int  status_seen [7];

    function automatic void clear_parse_state();
        byte_cnt    = 0;
        cur_phase   = PH_PREFIX;
        stage       = SC_SKIP;
        prefix_bad  = 1'b0;
        text_ended  = 1'b0;
        node_acc    = '0;
        service_acc = '0;
        node_fl     = '0;
        service_fl  = '0;
    endfunction

    function automatic void scan_number_byte(input logic [7:0] ch, inout logic [63:0] acc,
                                             inout scan_flags_t fl);
        logic [67:0] grown;
        if (stage == SC_SKIP)
        begin
            if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))
                return;
            if (ch == CH_PLUS || ch == CH_MINUS)
            begin
                fl.neg = fl.neg | (ch == CH_MINUS);
                stage  = SC_SIGN;
                return;
            end
        end
        if (stage == SC_STOP)
            return;
        if (ch < CH_ZERO || ch > CH_NINE)
        begin
            stage = SC_STOP;
            return;
        end
        stage  = SC_DIGITS;
        fl.dig = 1'b1;
        if (!fl.ovf)
        begin
            grown = 68'(acc) * 68'd10 + 68'(ch - CH_ZERO);
            if (grown[67:64] != 4'd0)
                fl.ovf = 1'b1;
            else
                acc = grown[63:0];
        end
    endfunction

    function automatic void parse_eid_byte(input logic [7:0] ch, input logic lst);
        int          pos;
        eid_result_t res;
        logic [63:0] node_val;
        logic [63:0] service_val;
        pos = byte_cnt;
        if (byte_cnt < MAX_LEN + 1)
            byte_cnt++;
        if (pos < 4)
        begin
            if (ch != PREFIX_TEXT[pos])
                prefix_bad = 1'b1;
            if (pos == 3)
                cur_phase = PH_NODE;
        end
        else if (!text_ended)
        begin
            if (ch == CH_NUL)
                text_ended = 1'b1;
            else if (cur_phase == PH_NODE)
            begin
                if (ch == CH_DOT)
                begin
                    cur_phase = PH_SERVICE;
                    stage     = SC_SKIP;
                end
                else
                    scan_number_byte(ch, node_acc, node_fl);
            end
            else if (cur_phase == PH_SERVICE)
                scan_number_byte(ch, service_acc, service_fl);
        end
        if (!lst)
            return;
        res.node    = '0;
        res.service = '0;
        if (byte_cnt < MIN_EID_LEN)
            res.status = ST_SHORT;
        else if (byte_cnt > MAX_LEN)
            res.status = ST_LONG;
        else if (prefix_bad)
            res.status = ST_PREFIX;
        else if (cur_phase != PH_SERVICE)
            res.status = ST_NO_DOT;
        else if (!node_fl.dig || node_fl.ovf)
            res.status = ST_BAD_NODE;
        else if (!service_fl.dig || service_fl.ovf)
            res.status = ST_BAD_SERVICE;
        else
        begin
            res.status  = ST_OK;
            node_val    = node_fl.neg ? 64'd0 - node_acc : node_acc;
            service_val = service_fl.neg ? 64'd0 - service_acc : service_acc;
            res.node    = node_val[31:0];
            res.service = service_val[31:0];
        end
        expected_ids.push_back(res);
        status_seen[res.status]++;
        clear_parse_state();
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        parse_eid_byte(ch, lst);
        bytes_sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic put_char(input logic [7:0] ch);
        text_buf.push_back(ch);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
        strings_sent++;
    endtask

    task automatic send_eid(input string s);
        put_text(s);
        send_text();
    endtask

    task automatic test_valid_numbers();
        send_eid("ipn:1.2");
        send_eid("ipn:0.0");
        send_eid("ipn:18446744073709551615.4294967295");
        send_eid("ipn:4294967296.007");
        send_eid("ipn:-1.+5");
        send_eid("ipn:-18446744073709551615.-0");
        put_text("ipn:");
        put_char(CH_SPACE);
        put_char(CH_TAB);
        put_char(8'h0a);
        put_char(8'h0b);
        put_char(8'h0c);
        put_char(CH_CR);
        put_text("7.  +42");
        send_text();
        send_eid("ipn:12ab.34.56");
        send_eid("ipn:1 2.3x");
    endtask

    task automatic test_number_errors();
        send_eid("ipn:18446744073709551616.1");
        send_eid("ipn:1.99999999999999999999");
        send_eid("ipn:.5");
        send_eid("ipn:5.");
        send_eid("ipn:+-3.4");
        send_eid("ipn:- 1.2");
        send_eid("ipn:7.-x");
        send_eid("ipn:123");
    endtask

    task automatic test_frame_errors();
        send_eid("i");
        send_eid("ipn:1.");
        send_eid("ipx:1.2");
        send_eid("IPN:1.2");
        put_text("ip");
        put_char(CH_NUL);
        put_text(":1.2");
        send_text();
        // exactly at the length limit and one past it
        put_text("ipn:1.2");
        repeat (MAX_LEN - 7) put_char(CH_SPACE);
        send_text();
        put_text("ipn:1.2");
        repeat (MAX_LEN - 6) put_char(CH_SPACE);
        send_text();
    endtask

    task automatic test_string_end();
        put_text("ipn:3.4");
        put_char(CH_NUL);
        put_text("xyz");
        send_text();
        put_text("ipn:3");
        put_char(CH_NUL);
        put_text(".4");
        send_text();
        put_text("ipn:");
        put_char(CH_NUL);
        put_text("1.2");
        send_text();
        put_text("ipn:5.6");
        put_char(CH_NUL);
        send_text();
    endtask

    task automatic put_rand_number();
        int  r;
        int  n;
        byte unsigned ws;
        if ($urandom_range(0, 9) < 2)
        begin
            repeat ($urandom_range(1, 2))
            begin
                ws = 8'($urandom_range(0, 5));
                put_char(ws == 0 ? CH_SPACE : CH_TAB + ws - 8'd1);
            end
        end
        r = $urandom_range(0, 99);
        if (r >= 85)
            put_char(CH_MINUS);
        else if (r >= 70)
            put_char(CH_PLUS);
        r = $urandom_range(0, 19);
        if (r == 0)
            return;
        if (r < 3)
        begin
            // just below or just above the 64-bit limit
            put_text("1844674407370955161");
            put_char(CH_ZERO + 8'($urandom_range(0, 9)));
            if (r == 2)
                put_char(CH_ZERO + 8'($urandom_range(0, 9)));
            return;
        end
        n = (r == 3) ? $urandom_range(20, 25) : $urandom_range(1, 10);
        repeat (n) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic put_rand_eid();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            put_text("ipn:");
            if ($urandom_range(0, 19) == 0)
                text_buf[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
            put_rand_number();
            if ($urandom_range(0, 99) < 93)
                put_char(CH_DOT);
            put_rand_number();
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 3))
                        0: put_char(CH_DOT);
                        1: put_char(CH_NUL);
                        2: put_char(CH_ZERO + 8'($urandom_range(0, 9)));
                        default: put_char(8'($urandom_range(0, 255)));
                    endcase
                end
            end
        end
        else if (r < 80)
        begin
            put_text("ipn:1.2");
            len = $urandom_range(MAX_LEN - 2, MAX_LEN + 8);
            while (text_buf.size() < len)
                put_char($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(0, 255)));
        end
        else if (r < 88)
        begin
            put_text("ipn:1.2");
            len = $urandom_range(1, MIN_EID_LEN - 1);
            while (text_buf.size() > len)
                void'(text_buf.pop_back());
        end
        else
        begin
            repeat ($urandom_range(1, 20)) put_char(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_strings();
        int first_byte;
        int first_string;
        first_byte   = bytes_sent;
        first_string = strings_sent;
        while (bytes_sent - first_byte < RAND_BYTES || strings_sent - first_string < RAND_STRINGS)
        begin
            if ((strings_sent % 8) == 0)
                quiet = ($urandom_range(0, 3) == 0);
            put_rand_eid();
            send_text();
        end
        quiet = 1'b0;
    endtask

    // result sink with random back-pressure
    always @(posedge clk)
    begin
        if (sink_stall > 0)
        begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
                sink_stall = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        eid_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_ids.size() == 0)
            begin
                $error("unexpected result transaction: tdata %h", m_axis_tdata);
                error_cnt++;
            end
            else
            begin
                want = expected_ids.pop_front();
                if (m_axis_tdata[2:0] !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_axis_tdata[2:0]);
                    error_cnt++;
                end
                if (m_axis_tdata[34:3] !== want.node)
                begin
                    $error("node_number: expected %0d, actual %0d", want.node,
                           m_axis_tdata[34:3]);
                    error_cnt++;
                end
                if (m_axis_tdata[66:35] !== want.service)
                begin
                    $error("service_number: expected %0d, actual %0d", want.service,
                           m_axis_tdata[66:35]);
                    error_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     expected_ids.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        clear_parse_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_valid_numbers();
        test_number_errors();
        test_frame_errors();
        test_string_end();
        test_random_strings();
        s_axis_tvalid <= 1'b0;
        while (expected_ids.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Parsed %0d strings in %0d bytes: %0d ok, %0d short, %0d long, %0d bad prefix,",
                 strings_sent, bytes_sent, status_seen[ST_OK], status_seen[ST_SHORT],
                 status_seen[ST_LONG], status_seen[ST_PREFIX]);
        $display("%0d without dot, %0d bad node, %0d bad service; %0d mismatches",
                 status_seen[ST_NO_DOT], status_seen[ST_BAD_NODE],
                 status_seen[ST_BAD_SERVICE], error_cnt);
        if (error_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
